>>> hw/rtl/ttpc_pkg.sv
// ----------------------------------------------------------------------------
// ttpc_pkg
// Shared widths, register indexes, reset values and the command and status
// words between the pump controller sequencer and its datapath.
// ----------------------------------------------------------------------------
package ttpc_pkg;

   localparam int DIST_W     = 9;
   localparam int PCT_W      = 7;
   localparam int HEIGHT_W   = 9;
   localparam int DELAY_W    = 8;
   localparam int NUM_W      = 16;
   localparam int DIV_STEPS  = 7;
   localparam int STEP_W     = 3;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 9;
   localparam int REQ_DATA_W = 24;
   localparam int RSP_DATA_W = 16;

   localparam logic [CSR_IDX_W-1:0] CSR_CISTERN_MIN = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_TANK_HEIGHT = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_TANK_MAX    = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_TANK_MIN    = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_CHECK_DELAY = 3'd4;

   localparam logic [PCT_W-1:0]    RST_CISTERN_MIN = 7'd20;
   localparam logic [HEIGHT_W-1:0] RST_TANK_HEIGHT = 9'd200;
   localparam logic [PCT_W-1:0]    RST_TANK_MAX    = 7'd80;
   localparam logic [PCT_W-1:0]    RST_TANK_MIN    = 7'd20;
   localparam logic [DELAY_W-1:0]  RST_CHECK_DELAY = 8'd30;
   localparam logic [PCT_W-1:0]    RST_TANK_PCT    = 7'd30;

   localparam logic [PCT_W:0]      CISTERN_MARGIN  = 8'd15;
   localparam logic [PCT_W-1:0]    PCT_FULL        = 7'd100;

   typedef struct packed {
      logic              load;
      logic              mul;
      logic              div_step;
      logic [STEP_W-1:0] div_shift;
      logic              commit;
   } cmd_type;

   typedef struct packed {
      logic need_div;
      logic out_free;
   } sts_type;

endpackage

>>> hw/rtl/two_tank_pump_controller_core.sv
// ----------------------------------------------------------------------------
// two_tank_pump_controller_core
// Tank level and pump supervisor, one result word per control tick.
//
// req_*  : one word per tick; tdata carries distance, cistern level, auto
//          mode and fault reset request; tuser flags a usable distance.
// rsp_*  : one word per accepted request: level, pump, fault, check state.
// csr_*  : register writes (index, data), ready outside reset, to be written
//          only when idle; the block itself does not enforce it.
// Steps:   a usable distance below the tank height goes from acceptance
//          to the result register through scale by 100, seven
//          restoring divide steps and commit; other words skip the scale
//          and divide. A new word is taken only once the last commits.
// A new request is taken while the previous result still waits; commit of
// that request holds until the result register is free, so a stalled
// receiver stalls the request side after one word.
// Reset clears the tick state (tank level 30%) and loads register defaults.
// ----------------------------------------------------------------------------
module two_tank_pump_controller_core (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   // [8:0] distance_cm, [15:9] cistern_pct, [16] auto_mode,
   // [17] reset_request, [23:18] zero
   input  logic [ttpc_pkg::REQ_DATA_W-1:0]    req_tdata,
   // [0] distance_valid
   input  logic                               req_tuser,
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   // [6:0] tank_level_pct, [7] pump_drive, [8] fault_flag,
   // [9] check_active, [15:10] zero
   output logic [ttpc_pkg::RSP_DATA_W-1:0]    rsp_tdata,
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [ttpc_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [ttpc_pkg::CSR_DATA_W-1:0]    csr_data
);

   ttpc_pkg::cmd_type cmd;
   ttpc_pkg::sts_type sts;

   assign csr_ready = !reset;

   ttpc_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .sts        (sts),
      .cmd        (cmd)
   );

   ttpc_dp u_dp (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .sts        (sts),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .csr_valid  (csr_valid),
      .csr_index  (csr_index),
      .csr_data   (csr_data),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

endmodule

>>> hw/rtl/ttpc_ctrl.sv
// ----------------------------------------------------------------------------
// ttpc_ctrl
// Sequencer: accept a word, scale height-distance, run the restoring divider
// one quotient bit per cycle, then commit the tick once the output is free.
// ----------------------------------------------------------------------------
module ttpc_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_tvalid,
   output logic              req_tready,
   input  ttpc_pkg::sts_type sts,
   output ttpc_pkg::cmd_type cmd
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_MUL,
      ST_DIV,
      ST_COMMIT
   } state_type;

   state_type                     state_ff;
   state_type                     state_in;
   logic [ttpc_pkg::STEP_W-1:0]   step_ff;
   logic [ttpc_pkg::STEP_W-1:0]   step_in;

   assign req_tready = (state_ff == ST_IDLE) && !reset;

   always_comb begin
      state_in      = state_ff;
      step_in       = step_ff;
      cmd           = '0;
      cmd.div_shift = step_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid && req_tready) begin
               cmd.load = 1'b1;
               state_in = ST_MUL;
            end
         end
         ST_MUL: begin
            if (sts.need_div) begin
               cmd.mul  = 1'b1;
               step_in  = ttpc_pkg::STEP_W'(ttpc_pkg::DIV_STEPS - 1);
               state_in = ST_DIV;
            end else begin
               state_in = ST_COMMIT;
            end
         end
         ST_DIV: begin
            cmd.div_step = 1'b1;
            if (step_ff == '0) begin
               state_in = ST_COMMIT;
            end else begin
               step_in = step_ff - 1'b1;
            end
         end
         ST_COMMIT: begin
            if (sts.out_free) begin
               cmd.commit = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         step_ff  <= '0;
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;
      end
   end

endmodule

>>> hw/rtl/ttpc_dp.sv
// ----------------------------------------------------------------------------
// ttpc_dp
// Datapath: configuration registers, input capture, level divider, pump
// hysteresis and fault check state, and the result register.
// ----------------------------------------------------------------------------
module ttpc_dp (
   input  logic                               clock,
   input  logic                               reset,
   input  ttpc_pkg::cmd_type                  cmd,
   output ttpc_pkg::sts_type                  sts,
   input  logic [ttpc_pkg::REQ_DATA_W-1:0]    req_tdata,
   input  logic                               req_tuser,
   input  logic                               csr_valid,
   input  logic [ttpc_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [ttpc_pkg::CSR_DATA_W-1:0]    csr_data,
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   output logic [ttpc_pkg::RSP_DATA_W-1:0]    rsp_tdata
);

   localparam int PW = ttpc_pkg::PCT_W;

   typedef struct packed {
      logic pump;
      logic latch;
   } hyst_type;

   function automatic hyst_type tank_hyst(input logic [PW-1:0] lvl,
                                          input logic [PW-1:0] lo,
                                          input logic [PW-1:0] hi,
                                          input hyst_type      cur);
      hyst_type r;
      r = cur;
      if (lvl <= lo) begin
         r.pump  = 1'b1;
         r.latch = 1'b1;
      end else if (lvl >= hi) begin
         r.pump  = 1'b0;
         r.latch = 1'b0;
      end
      if (lvl > lo && r.latch) begin
         r.pump = 1'b1;
      end
      return r;
   endfunction

   // configuration
   logic [PW-1:0]                     cis_min_ff;
   logic [ttpc_pkg::HEIGHT_W-1:0]     height_ff;
   logic [PW-1:0]                     tank_max_ff;
   logic [PW-1:0]                     tank_min_ff;
   logic [ttpc_pkg::DELAY_W-1:0]      delay_ff;

   // captured word
   logic [ttpc_pkg::DIST_W-1:0]       dist_ff;
   logic                              dvalid_ff;
   logic [PW-1:0]                     cistern_ff;
   logic                              auto_ff;
   logic                              rreq_ff;

   // divider
   logic [ttpc_pkg::NUM_W-1:0]        rem_ff;
   logic [PW-1:0]                     quot_ff;
   logic [ttpc_pkg::NUM_W-1:0]        div_sub;
   logic [ttpc_pkg::HEIGHT_W-1:0]     diff;

   // tick state
   logic [PW-1:0]                     tank_pct_ff, tank_pct_in;
   logic                              pump_ff, pump_in;
   logic                              tlatch_ff, tlatch_in;
   logic                              clatch_ff, clatch_in;
   logic                              fault_ff, fault_in;
   logic                              prev_pump_ff;
   logic                              busy_ff, busy_in;
   logic [ttpc_pkg::DELAY_W-1:0]      count_ff, count_in;
   logic [PW-1:0]                     capt_ff, capt_in;

   // result
   logic                              rsp_valid_ff;
   logic [ttpc_pkg::RSP_DATA_W-1:0]   rsp_data_ff;

   logic                              dist_low;
   logic [PW:0]                       cis_hi;
   logic [ttpc_pkg::DELAY_W-1:0]      delay_eff;
   hyst_type                          hy;

   assign dist_low     = dist_ff < ttpc_pkg::DIST_W'(height_ff);
   assign sts.need_div = dvalid_ff && dist_low;
   assign sts.out_free = !rsp_valid_ff || rsp_tready;
   assign diff         = height_ff - ttpc_pkg::HEIGHT_W'(dist_ff);
   assign div_sub      = ttpc_pkg::NUM_W'(height_ff) << cmd.div_shift;
   assign cis_hi       = {1'b0, cis_min_ff} + ttpc_pkg::CISTERN_MARGIN;
   assign delay_eff    = (delay_ff == '0) ? ttpc_pkg::DELAY_W'(1) : delay_ff;

   always_comb begin
      tank_pct_in = tank_pct_ff;
      if (dvalid_ff) begin
         tank_pct_in = dist_low ? quot_ff : '0;
      end

      hy.pump  = pump_ff;
      hy.latch = tlatch_ff;
      clatch_in = clatch_ff;
      fault_in  = fault_ff;

      if (auto_ff && !fault_ff) begin
         if (cistern_ff <= cis_min_ff) begin
            hy.pump   = 1'b0;
            clatch_in = 1'b0;
         end else if ({1'b0, cistern_ff} >= cis_hi) begin
            hy        = tank_hyst(tank_pct_in, tank_min_ff, tank_max_ff, hy);
            clatch_in = 1'b1;
         end
         if ({1'b0, cistern_ff} < cis_hi && clatch_in) begin
            hy = tank_hyst(tank_pct_in, tank_min_ff, tank_max_ff, hy);
         end
      end else if (!auto_ff) begin
         if (tank_pct_in >= tank_max_ff) begin
            hy.pump = 1'b0;
         end
      end

      if (fault_ff) begin
         hy.pump = 1'b0;
         if (rreq_ff) begin
            fault_in = 1'b0;
         end
      end

      pump_in   = hy.pump;
      tlatch_in = hy.latch;
      busy_in   = busy_ff;
      count_in  = count_ff;
      capt_in   = capt_ff;
      if (!busy_ff) begin
         if (pump_in && !prev_pump_ff) begin
            capt_in  = tank_pct_in;
            busy_in  = 1'b1;
            count_in = '0;
         end
      end else begin
         count_in = count_ff + 1'b1;
         if (count_in >= delay_eff) begin
            busy_in  = 1'b0;
            fault_in = !(tank_pct_in > capt_ff);
         end
      end
   end

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cis_min_ff  <= ttpc_pkg::RST_CISTERN_MIN;
         height_ff   <= ttpc_pkg::RST_TANK_HEIGHT;
         tank_max_ff <= ttpc_pkg::RST_TANK_MAX;
         tank_min_ff <= ttpc_pkg::RST_TANK_MIN;
         delay_ff    <= ttpc_pkg::RST_CHECK_DELAY;
      end else if (csr_valid) begin
         unique case (csr_index)
            ttpc_pkg::CSR_CISTERN_MIN: cis_min_ff  <= csr_data[PW-1:0];
            ttpc_pkg::CSR_TANK_HEIGHT: height_ff   <= csr_data[ttpc_pkg::HEIGHT_W-1:0];
            ttpc_pkg::CSR_TANK_MAX:    tank_max_ff <= csr_data[PW-1:0];
            ttpc_pkg::CSR_TANK_MIN:    tank_min_ff <= csr_data[PW-1:0];
            ttpc_pkg::CSR_CHECK_DELAY: delay_ff    <= csr_data[ttpc_pkg::DELAY_W-1:0];
            default: ;
         endcase
      end
   end

   // input capture and divider
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         dist_ff    <= req_tdata[ttpc_pkg::DIST_W-1:0];
         cistern_ff <= req_tdata[ttpc_pkg::DIST_W +: PW];
         auto_ff    <= req_tdata[ttpc_pkg::DIST_W + PW];
         rreq_ff    <= req_tdata[ttpc_pkg::DIST_W + PW + 1];
         dvalid_ff  <= req_tuser;
      end
      if (cmd.mul) begin
         rem_ff  <= ttpc_pkg::NUM_W'(diff) * ttpc_pkg::NUM_W'(ttpc_pkg::PCT_FULL);
         quot_ff <= '0;
      end else if (cmd.div_step) begin
         if (rem_ff >= div_sub) begin
            rem_ff                 <= rem_ff - div_sub;
            quot_ff[cmd.div_shift] <= 1'b1;
         end
      end
   end

   // tick state
   always_ff @(posedge clock) begin
      if (reset) begin
         tank_pct_ff  <= ttpc_pkg::RST_TANK_PCT;
         pump_ff      <= 1'b0;
         tlatch_ff    <= 1'b0;
         clatch_ff    <= 1'b0;
         fault_ff     <= 1'b0;
         prev_pump_ff <= 1'b0;
         busy_ff      <= 1'b0;
         count_ff     <= '0;
         capt_ff      <= '0;
      end else if (cmd.commit) begin
         tank_pct_ff  <= tank_pct_in;
         pump_ff      <= pump_in;
         tlatch_ff    <= tlatch_in;
         clatch_ff    <= clatch_in;
         fault_ff     <= fault_in;
         prev_pump_ff <= pump_in;
         busy_ff      <= busy_in;
         count_ff     <= count_in;
         capt_ff      <= capt_in;
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.commit) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
      if (cmd.commit) begin
         rsp_data_ff <= {6'd0, busy_in, fault_in, pump_in, tank_pct_in};
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule
